// ===== hdl/sol_pkg.sv =====
// Shared types and constants for the source offset to line/column block.
package sol_pkg;

    // Default sizing of the line-start table.
    localparam int MAX_LINES_DEF   = 1024;
    localparam int OFFSET_BITS_DEF = 20;

    // Fixed field widths of the channels.
    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int SPAN_W = 20;
    localparam int LINE_W = 11;
    localparam int COL_W  = 21;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

    // One input beat.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [BYTE_W-1:0] source_byte;
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_length;
    } sol_in_t;

    // One result beat.
    typedef struct packed {
        logic [LINE_W-1:0] start_line;
        logic [COL_W-1:0]  start_column;
        logic [LINE_W-1:0] end_line;
        logic [COL_W-1:0]  end_column;
        logic              status;
    } sol_out_t;

    // Answer of one search, handed from the search unit to the sequencer.
    typedef struct packed {
        logic              done;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
    } sol_find_res_t;

endpackage

// ===== hdl/sol_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/sol_table.sv =====
// Byte counter and line-start writer that fills the line-start table.
module sol_table #(
    parameter int MAX_LINES   = sol_pkg::MAX_LINES_DEF,
    parameter int OFFSET_BITS = sol_pkg::OFFSET_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  logic                                byte_go,
    input  logic [sol_pkg::BYTE_W-1:0]          source_byte,
    output logic [$clog2(MAX_LINES+1)-1:0]      line_count,
    output logic                                overflowed,
    output logic                                wr_en,
    output logic [$clog2(MAX_LINES)-1:0]        wr_addr,
    output logic [OFFSET_BITS-1:0]              wr_data
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int IDX_W = $clog2(MAX_LINES);
    localparam int POS_W = OFFSET_BITS + 1;

    logic [CNT_W-1:0] line_count_reg, line_count_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic             overflowed_reg, overflowed_next;

    logic             newline;
    logic [POS_W:0]   next_start;
    logic             fits;
    logic             room;

    // A newline records the offset of the byte after it, if it fits and the table has room.
    always_comb
    begin
        newline    = byte_go && (source_byte == sol_pkg::NEWLINE_CHAR);
        next_start = {1'b0, byte_pos_reg} + {{POS_W{1'b0}}, 1'b1};
        fits       = (next_start[POS_W:OFFSET_BITS] == '0);
        room       = (line_count_reg < CNT_W'(MAX_LINES));
        wr_en      = newline && fits && room;
        wr_addr    = line_count_reg[IDX_W-1:0];
        wr_data    = next_start[OFFSET_BITS-1:0];
    end

    // Counters and the overflow flag.
    always_comb
    begin
        line_count_next = line_count_reg;
        byte_pos_next   = byte_pos_reg;
        overflowed_next = overflowed_reg;
        if (clear)
        begin
            line_count_next = CNT_W'(1);
            byte_pos_next   = '0;
            overflowed_next = 1'b0;
        end
        else if (byte_go)
        begin
            if (wr_en)
            begin
                line_count_next = line_count_reg + CNT_W'(1);
            end
            else if (newline)
            begin
                overflowed_next = 1'b1;
            end
            if (byte_pos_reg != {POS_W{1'b1}})
            begin
                byte_pos_next = byte_pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_count_reg <= CNT_W'(1);
            byte_pos_reg   <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            line_count_reg <= line_count_next;
            byte_pos_reg   <= byte_pos_next;
            overflowed_reg <= overflowed_next;
        end
    end

    assign line_count = line_count_reg;
    assign overflowed = overflowed_reg;

    // The table always holds at least the first line and never more than it can.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (line_count_reg >= CNT_W'(1)) && (line_count_reg <= CNT_W'(MAX_LINES)))
        else $error("line count out of range");

    // Every table write adds exactly one line.
    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (line_count_reg == $past(line_count_reg) + CNT_W'(1)))
        else $error("table write did not advance the line count");

endmodule

// ===== hdl/sol_search.sv =====
// Binary search over the line-start table, one probe per cycle.
module sol_search #(
    parameter int MAX_LINES   = sol_pkg::MAX_LINES_DEF,
    parameter int OFFSET_BITS = sol_pkg::OFFSET_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [sol_pkg::COL_W-1:0]         go_pos,
    input  logic [$clog2(MAX_LINES+1)-1:0]    line_count,
    output logic                              rd_en,
    output logic [$clog2(MAX_LINES)-1:0]      rd_addr,
    input  logic [OFFSET_BITS-1:0]            rd_data,
    output sol_pkg::sol_find_res_t            res
);

    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int IDX_W  = $clog2(MAX_LINES);
    localparam int COL_W  = sol_pkg::COL_W;
    localparam int LINE_W = sol_pkg::LINE_W;
    localparam int CMP_W  = (COL_W > OFFSET_BITS) ? COL_W : OFFSET_BITS;
    localparam int LSUM_W = (IDX_W + 1 > LINE_W) ? IDX_W + 1 : LINE_W;

    logic                   busy_reg, busy_next;
    logic [COL_W-1:0]       pos_reg, pos_next;
    logic [IDX_W-1:0]       lo_reg, lo_next;
    logic [OFFSET_BITS-1:0] lo_val_reg, lo_val_next;
    logic [CNT_W-1:0]       span_reg, span_next;
    logic [IDX_W-1:0]       probe_reg, probe_next;

    logic                   step;
    logic                   ge;
    logic [IDX_W-1:0]       lo_step;
    logic [OFFSET_BITS-1:0] val_step;
    logic [CNT_W-1:0]       span_step;
    logic [IDX_W-1:0]       probe_step;
    logic [LSUM_W-1:0]      line_sum;

    // One narrowing step: the data for probe_reg arrived this cycle.
    always_comb
    begin
        step       = busy_reg && (span_reg > CNT_W'(1));
        ge         = (CMP_W'(pos_reg) >= CMP_W'(rd_data));
        lo_step    = ge ? probe_reg : lo_reg;
        val_step   = ge ? rd_data : lo_val_reg;
        span_step  = span_reg - (span_reg >> 1);
        probe_step = IDX_W'(CNT_W'(lo_step) + (span_step >> 1));
    end

    // Search state and the next table read.
    always_comb
    begin
        busy_next   = busy_reg;
        pos_next    = pos_reg;
        lo_next     = lo_reg;
        lo_val_next = lo_val_reg;
        span_next   = span_reg;
        probe_next  = probe_reg;
        rd_en       = 1'b0;
        rd_addr     = probe_step;
        if (go)
        begin
            busy_next   = 1'b1;
            pos_next    = go_pos;
            lo_next     = '0;
            lo_val_next = '0;
            span_next   = line_count;
            probe_next  = IDX_W'(line_count >> 1);
            rd_en       = (line_count > CNT_W'(1));
            rd_addr     = IDX_W'(line_count >> 1);
        end
        else if (step)
        begin
            lo_next     = lo_step;
            lo_val_next = val_step;
            span_next   = span_step;
            probe_next  = probe_step;
            rd_en       = (span_step > CNT_W'(1));
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        lo_reg     <= lo_next;
        lo_val_reg <= lo_val_next;
        span_reg   <= span_next;
        probe_reg  <= probe_next;
    end

    // Answer once the window is down to one line.
    always_comb
    begin
        line_sum   = LSUM_W'(lo_reg) + LSUM_W'(1);
        res.done   = busy_reg && (span_reg <= CNT_W'(1));
        res.line   = line_sum[LINE_W-1:0];
        res.column = pos_reg - COL_W'(lo_val_reg) + COL_W'(1);
    end

    // Probes only touch lines that have been recorded.
    a_probe_written: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (CNT_W'(rd_addr) < line_count))
        else $error("search read an unrecorded line start");

endmodule

// ===== hdl/source_offset_to_line_column_core.sv =====
// Top level of the source offset to line/column converter.
//
// One input channel (in_valid/in_ready/in_data) carries commands; one output
// channel (out_valid/out_ready/out_data) carries span answers. A clear beat
// starts a new source, and a byte beat appends one source byte; both give no
// result. A query beat (span start and length) gives one result beat with the
// line and column of the first and last byte of the span. Each query runs up
// to two binary searches over the line-start table, one table read per cycle,
// and no new beat is accepted until the sequencer is back in idle. The table
// RAM's single read port paces the searches. The result waits in an output
// register; while it waits, clear and byte beats are still taken, and a later
// query completes its searches and then holds until the output register
// frees. Reset leaves an empty source of one line with the overflow flag low;
// the RAM needs no clearing pass.
module source_offset_to_line_column_core #(
    parameter int MAX_LINES   = sol_pkg::MAX_LINES_DEF,
    parameter int OFFSET_BITS = sol_pkg::OFFSET_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sol_pkg::sol_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output sol_pkg::sol_out_t out_data
);

    localparam int CNT_W = $clog2(MAX_LINES + 1);
    localparam int IDX_W = $clog2(MAX_LINES);
    localparam int COL_W = sol_pkg::COL_W;

    typedef enum logic [3:0] {
        ST_IDLE       = 4'b0001,
        ST_FIND_START = 4'b0010,
        ST_FIND_END   = 4'b0100,
        ST_HOLD       = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;
    sol_pkg::sol_out_t      out_data_reg, out_data_next;
    sol_pkg::sol_out_t      pend_reg, pend_next;
    logic [COL_W-1:0]       end_pos_reg, end_pos_next;
    logic                   zero_len_reg, zero_len_next;
    logic [sol_pkg::LINE_W-1:0] start_line_reg, start_line_next;
    logic [COL_W-1:0]       start_col_reg, start_col_next;

    logic                   accept;
    logic                   tbl_clear;
    logic                   tbl_byte;
    logic                   query_go;
    logic [CNT_W-1:0]       line_count;
    logic                   overflowed;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [OFFSET_BITS-1:0] wr_data;
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [OFFSET_BITS-1:0] rd_data;
    logic                   find_go;
    logic [COL_W-1:0]       find_pos;
    sol_pkg::sol_find_res_t find_res;
    logic                   finish;
    sol_pkg::sol_out_t      fin_data;
    logic                   slot_free;

    // Input decode.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        accept    = in_valid && in_ready;
        tbl_clear = accept && (in_data.command == sol_pkg::CMD_CLEAR);
        tbl_byte  = accept && (in_data.command == sol_pkg::CMD_BYTE);
        query_go  = accept && (in_data.command == sol_pkg::CMD_QUERY);
    end

    sol_table #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (tbl_clear),
        .byte_go     (tbl_byte),
        .source_byte (in_data.source_byte),
        .line_count  (line_count),
        .overflowed  (overflowed),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data)
    );

    sol_ram #(
        .WIDTH (OFFSET_BITS),
        .DEPTH (MAX_LINES)
    ) u_line_starts (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sol_search #(
        .MAX_LINES   (MAX_LINES),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_search (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (find_go),
        .go_pos     (find_pos),
        .line_count (line_count),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .res        (find_res)
    );

    // Launch the start search on acceptance, the end search after it.
    always_comb
    begin
        find_go  = query_go;
        find_pos = {1'b0, in_data.span_start};
        if ((state_reg == ST_FIND_START) && find_res.done && !zero_len_reg)
        begin
            find_go  = 1'b1;
            find_pos = end_pos_reg;
        end
    end

    // Assemble a finished answer.
    always_comb
    begin
        finish = find_res.done &&
                 (((state_reg == ST_FIND_START) && zero_len_reg) ||
                  (state_reg == ST_FIND_END));
        fin_data.start_line   = start_line_reg;
        fin_data.start_column = start_col_reg;
        if (state_reg == ST_FIND_START)
        begin
            fin_data.start_line   = find_res.line;
            fin_data.start_column = find_res.column;
        end
        fin_data.end_line   = find_res.line;
        fin_data.end_column = find_res.column;
        fin_data.status     = overflowed;
        slot_free           = !out_valid_reg || out_ready;
    end

    // Sequencer and output register.
    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        pend_next       = pend_reg;
        end_pos_next    = end_pos_reg;
        zero_len_next   = zero_len_reg;
        start_line_next = start_line_reg;
        start_col_next  = start_col_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_go)
                begin
                    end_pos_next  = COL_W'({1'b0, in_data.span_start}
                                         + {1'b0, in_data.span_length} - 21'd1);
                    zero_len_next = (in_data.span_length == '0);
                    state_next    = ST_FIND_START;
                end
            end
            ST_FIND_START:
            begin
                if (find_res.done)
                begin
                    start_line_next = find_res.line;
                    start_col_next  = find_res.column;
                    if (!zero_len_reg)
                    begin
                        state_next = ST_FIND_END;
                    end
                end
            end
            ST_FIND_END:
            begin
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (finish)
        begin
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_data_next  = fin_data;
                state_next     = ST_IDLE;
            end
            else
            begin
                pend_next  = fin_data;
                state_next = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        pend_reg       <= pend_next;
        end_pos_reg    <= end_pos_next;
        zero_len_reg   <= zero_len_next;
        start_line_reg <= start_line_next;
        start_col_reg  <= start_col_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A search answer only arrives while a query is being worked on.
    a_done_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        find_res.done |-> ((state_reg == ST_FIND_START) || (state_reg == ST_FIND_END)))
        else $error("search answer outside a query");

    // The table is never written while a query is searching it.
    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FIND_START) || (state_reg == ST_FIND_END)) |-> !wr_en)
        else $error("table written during a search");

endmodule
